// ===== rtl/ps2m_pkg.sv =====
// shared types and constants for the ps2 mouse packet cursor tracker
// no dependencies; used by every rtl file of the block
package ps2m_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned DeltaW   = 9;
  localparam int unsigned LimitW   = 12;
  localparam int unsigned PosW     = 12;
  localparam int unsigned ButtonW  = 3;
  localparam int unsigned CfgIdxW  = 1;

  // header byte bit positions
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegXLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] RegYLimit = 1'b1;

  localparam logic [LimitW-1:0] XLimitReset = 12'd1023;
  localparam logic [LimitW-1:0] YLimitReset = 12'd767;

  localparam int unsigned CursorXReset = 512;
  localparam int unsigned CursorYReset = 384;

  // one decoded packet, valid when done is set
  typedef struct packed {
    logic                     done;
    logic [ButtonW-1:0]       buttons;
    logic signed [DeltaW-1:0] move_x;
    logic signed [DeltaW-1:0] move_y;
  } pkt_t;

endpackage

// ===== rtl/ps2_mouse_packet_cursor_tracker.sv =====
// Takes one received PS/2 mouse byte per request and gathers standard three-byte
// packets; bytes without bit 3 set are dropped while waiting for a header. Each
// completed packet gives one result: cursor X and Y after adding the deltas (Y
// subtracted, screen down positive) and clamping to 0..limit, the three button
// bits and the two sign-extended deltas. A byte is accepted every cycle while
// results drain; the result of a packet passes through the input register, then
// the result register, after its third byte is accepted. While a result waits
// unaccepted, the input register takes one more byte and then holds off further
// requests until the result is taken. Cursor resets to 512, 384; limits reset
// to 1023, 767.
// depends on ps2m_pkg, ps2m_packet_decoder and ps2m_cursor_update
module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ps2m_pkg::ByteW-1:0]          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ps2m_pkg::PosW-1:0]           pos_x_o,
  output logic [ps2m_pkg::PosW-1:0]           pos_y_o,
  output logic [ps2m_pkg::ButtonW-1:0]        button_bits_o,
  output logic signed [ps2m_pkg::DeltaW-1:0]  move_x_o,
  output logic signed [ps2m_pkg::DeltaW-1:0]  move_y_o,
  input  logic                                cfg_we_i,
  input  logic [ps2m_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ps2m_pkg::LimitW-1:0]         cfg_wdata_i
);

  logic                        in_valid_q;
  logic [ps2m_pkg::ByteW-1:0]  in_byte_q;
  logic                        advance, step, emit;
  logic [ps2m_pkg::LimitW-1:0] x_limit_q, y_limit_q;
  logic [ps2m_pkg::PosW-1:0]   next_x, next_y;
  ps2m_pkg::pkt_t              pkt;

  // the result register frees up this cycle or is already empty
  assign advance    = !out_valid_o || out_ready_i;
  assign step       = in_valid_q && advance;
  assign emit       = step && pkt.done;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= ps2m_pkg::XLimitReset;
      y_limit_q <= ps2m_pkg::YLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ps2m_pkg::RegXLimit: x_limit_q <= cfg_wdata_i;
        ps2m_pkg::RegYLimit: y_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  ps2m_packet_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .pkt_o  (pkt)
  );

  ps2m_cursor_update #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (emit),
    .move_x_i  (pkt.move_x),
    .move_y_i  (pkt.move_y),
    .x_limit_i (x_limit_q),
    .y_limit_i (y_limit_q),
    .pos_x_o   (next_x),
    .pos_y_o   (next_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pos_x_o       <= next_x;
      pos_y_o       <= next_y;
      button_bits_o <= pkt.buttons;
      move_x_o      <= pkt.move_x;
      move_y_o      <= pkt.move_y;
    end
  end

endmodule

// ===== rtl/ps2m_packet_decoder.sv =====
// byte framing for the three-byte ps2 mouse packet: phase, header and x byte
// depends on ps2m_pkg for the packet struct and header bit positions
module ps2m_packet_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [ps2m_pkg::ByteW-1:0]   byte_i,
  output ps2m_pkg::pkt_t               pkt_o
);

  localparam logic [1:0] PhaseHeader = 2'd0;
  localparam logic [1:0] PhaseX      = 2'd1;
  localparam logic [1:0] PhaseY      = 2'd2;

  logic [1:0]                 phase_q, phase_d;
  logic [ps2m_pkg::ByteW-1:0] header_q, header_d;
  logic [ps2m_pkg::ByteW-1:0] xbyte_q, xbyte_d;

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    xbyte_d  = xbyte_q;
    pkt_o.done = 1'b0;
    unique case (phase_q)
      PhaseX: begin
        xbyte_d = byte_i;
        phase_d = PhaseY;
      end
      PhaseY: begin
        pkt_o.done = 1'b1;
        phase_d    = PhaseHeader;
      end
      default: begin
        // unused phase behaves as waiting for a header
        if (byte_i[ps2m_pkg::HdrSyncBit]) begin
          header_d = byte_i;
          phase_d  = PhaseX;
        end
      end
    endcase
    pkt_o.buttons = header_q[ps2m_pkg::ButtonW-1:0];
    pkt_o.move_x  = {header_q[ps2m_pkg::HdrXSignBit], xbyte_q};
    pkt_o.move_y  = {header_q[ps2m_pkg::HdrYSignBit], byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhaseHeader;
      header_q <= '0;
      xbyte_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      header_q <= header_d;
      xbyte_q  <= xbyte_d;
    end
  end

endmodule

// ===== rtl/ps2m_cursor_update.sv =====
// cursor x and y registers with delta add and clamp to the configured ceiling
// depends on ps2m_pkg for widths and reset positions
module ps2m_cursor_update #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic signed [ps2m_pkg::DeltaW-1:0] move_x_i,
  input  logic signed [ps2m_pkg::DeltaW-1:0] move_y_i,
  input  logic [ps2m_pkg::LimitW-1:0]        x_limit_i,
  input  logic [ps2m_pkg::LimitW-1:0]        y_limit_i,
  output logic [ps2m_pkg::PosW-1:0]          pos_x_o,
  output logic [ps2m_pkg::PosW-1:0]          pos_y_o
);

  // two extra bits: one for carry, one for sign
  localparam int unsigned SumW  = COORD_BITS + 2;
  localparam int unsigned LimW  = (SumW > ps2m_pkg::LimitW) ? SumW : ps2m_pkg::LimitW;

  logic [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic [SumW-1:0]       sum_x, sum_y;
  logic [LimW-1:0]       coord_max, top_x, top_y, lim_x, lim_y, mag_x, mag_y;

  function automatic logic [LimW-1:0] clamp(input logic [SumW-1:0] v,
                                            input logic [LimW-1:0] top);
    logic [LimW-1:0] mag;
    mag = LimW'(v);
    if (v[SumW-1]) begin
      clamp = '0;
    end else if (mag > top) begin
      clamp = top;
    end else begin
      clamp = mag;
    end
  endfunction

  always_comb begin
    coord_max = LimW'({COORD_BITS{1'b1}});
    lim_x     = LimW'(x_limit_i);
    lim_y     = LimW'(y_limit_i);
    top_x     = (lim_x > coord_max) ? coord_max : lim_x;
    top_y     = (lim_y > coord_max) ? coord_max : lim_y;
    // screen y grows downward, so the mouse y delta is subtracted
    sum_x = SumW'({2'b00, cur_x_q}) + {{(SumW-ps2m_pkg::DeltaW){move_x_i[ps2m_pkg::DeltaW-1]}},
                                        move_x_i};
    sum_y = SumW'({2'b00, cur_y_q}) - {{(SumW-ps2m_pkg::DeltaW){move_y_i[ps2m_pkg::DeltaW-1]}},
                                        move_y_i};
    mag_x   = clamp(sum_x, top_x);
    mag_y   = clamp(sum_y, top_y);
    cur_x_d = COORD_BITS'(mag_x);
    cur_y_d = COORD_BITS'(mag_y);
    pos_x_o = ps2m_pkg::PosW'(cur_x_d);
    pos_y_o = ps2m_pkg::PosW'(cur_y_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= COORD_BITS'(ps2m_pkg::CursorXReset);
      cur_y_q <= COORD_BITS'(ps2m_pkg::CursorYReset);
    end else if (step_i) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

endmodule
